// ----- rtl/lsda_pkg.sv -----
package lsda_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int VALUE_W = 32;
    localparam int INDEX_W = 6;
    localparam int COUNT_W = 7;

    typedef logic [1:0] t_op;
    typedef logic [1:0] t_status;

    localparam t_op OP_PUSH   = 2'd0;
    localparam t_op OP_POP    = 2'd1;
    localparam t_op OP_DELETE = 2'd2;
    localparam t_op OP_CLEAR  = 2'd3;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_OVERFLOW  = 2'd1;
    localparam t_status ST_UNDERFLOW = 2'd2;
    localparam t_status ST_BAD_INDEX = 2'd3;

endpackage

// ----- rtl/lsda_store.sv -----
module lsda_store #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [$clog2(DEPTH)-1:0]     i_waddr,
    input  logic [DATA_WIDTH-1:0]        i_wdata,
    input  logic [$clog2(DEPTH)-1:0]     i_raddr,
    output logic [DATA_WIDTH-1:0]        o_rdata
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/lifo_stack_with_delete_at.sv -----
// Channel   Handshake                   Payload
// -------   -------------------------   ----------------------------------------------
// command   start, busy (taken on       i_operation, i_push_value, i_delete_index
//           start high, busy low)
// result    o_result_valid (one cycle)  o_popped_value, o_status, o_entry_count
//
// Push, clear, delete of the top entry and every rejected command: result in the cycle after the
// command is taken, and busy stays low, so commands may follow every cycle.
// Pop: the result passes the registered read of the store and then the S_POP state.
// Delete at index k below the top entry: the shift moves one entry per cycle
// through the one read port and one write port of the store.
// Reset (synchronous, active low) empties the stack; the store itself is not cleared.
// The receiver cannot stall: each result beat is on the ports for exactly one cycle.
module lifo_stack_with_delete_at #(
    parameter int DEPTH      = lsda_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = lsda_pkg::DATA_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  lsda_pkg::t_op                       i_operation,
    input  logic [lsda_pkg::VALUE_W-1:0]        i_push_value,
    input  logic [lsda_pkg::INDEX_W-1:0]        i_delete_index,
    output logic                                o_result_valid,
    output logic [lsda_pkg::VALUE_W-1:0]        o_popped_value,
    output lsda_pkg::t_status                   o_status,
    output logic [lsda_pkg::COUNT_W-1:0]        o_entry_count
);

    import lsda_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = CW + INDEX_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_POP   = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;

    logic [1:0]            r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [AW-1:0]         r_ptr, n_ptr;
    logic                  r_res_valid, n_res_valid;
    logic [VALUE_W-1:0]    r_value, n_value;
    t_status               r_status, n_status;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic [AW-1:0]         mem_raddr;
    logic [DATA_WIDTH-1:0] mem_rdata;

    logic [63:0]           push_ext;
    logic [63:0]           rd_ext;
    logic [IW-1:0]         idx_ext;
    logic [IW-1:0]         cnt_ext;
    logic [CW+COUNT_W-1:0] cnt_out_ext;

    assign push_ext    = 64'(i_push_value);
    assign rd_ext      = 64'(mem_rdata);
    assign idx_ext     = IW'(i_delete_index);
    assign cnt_ext     = IW'(r_count);
    assign cnt_out_ext = (CW + COUNT_W)'(r_count);

    lsda_store #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_res_valid = 1'b0;
        n_value     = r_value;
        n_status    = r_status;
        mem_we      = 1'b0;
        mem_waddr   = r_count[AW-1:0];
        mem_wdata   = push_ext[DATA_WIDTH-1:0];
        mem_raddr   = r_ptr;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_res_valid = 1'b1;
                    n_value     = '0;
                    n_status    = ST_OK;
                    unique case (i_operation)
                        OP_PUSH: begin
                            if (r_count == CW'(DEPTH)) begin
                                n_status = ST_OVERFLOW;
                            end else begin
                                mem_we  = 1'b1;
                                n_count = r_count + CW'(1);
                            end
                        end
                        OP_POP: begin
                            if (r_count == '0) begin
                                n_status = ST_UNDERFLOW;
                            end else begin
                                mem_raddr   = AW'(r_count - CW'(1));
                                n_count     = r_count - CW'(1);
                                n_res_valid = 1'b0;
                                n_state     = S_POP;
                            end
                        end
                        OP_DELETE: begin
                            if (idx_ext >= cnt_ext) begin
                                n_status = ST_BAD_INDEX;
                            end else if (idx_ext + IW'(1) == cnt_ext) begin
                                n_count = r_count - CW'(1);
                            end else begin
                                mem_raddr   = AW'(idx_ext + IW'(1));
                                n_ptr       = AW'(idx_ext + IW'(1));
                                n_res_valid = 1'b0;
                                n_state     = S_SHIFT;
                            end
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                            n_count = r_count;
                        end
                    endcase
                end
            end
            S_POP: begin
                n_res_valid = 1'b1;
                n_value     = rd_ext[VALUE_W-1:0];
                n_status    = ST_OK;
                n_state     = S_IDLE;
            end
            S_SHIFT: begin
                mem_we    = 1'b1;
                mem_waddr = r_ptr - AW'(1);
                mem_wdata = mem_rdata;
                if (CW'(r_ptr) + CW'(1) < r_count) begin
                    mem_raddr = r_ptr + AW'(1);
                    n_ptr     = r_ptr + AW'(1);
                end else begin
                    n_count     = r_count - CW'(1);
                    n_res_valid = 1'b1;
                    n_value     = '0;
                    n_status    = ST_OK;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_value  <= n_value;
        r_status <= n_status;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_res_valid;
    assign o_popped_value = r_value;
    assign o_status       = r_status;
    assign o_entry_count  = cnt_out_ext[COUNT_W-1:0];

endmodule

// ----- rtl/lsda_checker.sv -----
module lsda_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                start,
    input logic                                busy,
    input lsda_pkg::t_op                       i_operation,
    input logic [lsda_pkg::VALUE_W-1:0]        i_push_value,
    input logic [lsda_pkg::INDEX_W-1:0]        i_delete_index,
    input logic                                o_result_valid,
    input logic [lsda_pkg::VALUE_W-1:0]        o_popped_value,
    input lsda_pkg::t_status                   o_status,
    input logic [lsda_pkg::COUNT_W-1:0]        o_entry_count
);

    import lsda_pkg::*;

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_result_valid || busy))
        else $error("taken command gave neither a result beat nor busy");

    a_no_beat_unasked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !$past(busy)) |-> $past(start))
        else $error("result beat without a taken command");

    a_value_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status != ST_OK) |-> (o_popped_value == '0))
        else $error("nonzero value on a failed command");

    a_underflow_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status == ST_UNDERFLOW) |-> (o_entry_count == '0))
        else $error("underflow reported with entries held");

    a_no_beat_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && $past(busy)) |-> !o_result_valid)
        else $error("result beat while the shift or pop is still running");

endmodule

bind lifo_stack_with_delete_at lsda_checker u_lsda_checker (.*);

// ----- tb/sv/lifo_stack_with_delete_at_test.sv -----
`timescale 1ns / 100ps

module lifo_stack_with_delete_at_test;
    import lsda_pkg::*;

    localparam int STACK_DEPTH = DEPTH_DEF;

    typedef struct {
        logic [VALUE_W-1:0] popped_value;
        t_status            status;
        logic [COUNT_W-1:0] entry_count;
    } t_stack_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    t_op                i_operation;
    logic [VALUE_W-1:0] i_push_value;
    logic [INDEX_W-1:0] i_delete_index;
    logic               o_result_valid;
    logic [VALUE_W-1:0] o_popped_value;
    t_status            o_status;
    logic [COUNT_W-1:0] o_entry_count;

    logic [VALUE_W-1:0] shadow_stack [STACK_DEPTH];
    int unsigned        shadow_fill;
    t_stack_result      pending_results [$];
    int                 mismatch_count;

    lifo_stack_with_delete_at dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_push_value   (i_push_value),
        .i_delete_index (i_delete_index),
        .o_result_valid (o_result_valid),
        .o_popped_value (o_popped_value),
        .o_status       (o_status),
        .o_entry_count  (o_entry_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic t_stack_result apply_stack_op(t_op op, logic [VALUE_W-1:0] value,
                                                     logic [INDEX_W-1:0] index);
        t_stack_result res;
        res.popped_value = '0;
        res.status       = ST_OK;
        case (op)
            OP_PUSH: begin
                if (shadow_fill >= STACK_DEPTH) begin
                    res.status = ST_OVERFLOW;
                end else begin
                    shadow_stack[shadow_fill] = value;
                    shadow_fill++;
                end
            end
            OP_POP: begin
                if (shadow_fill == 0) begin
                    res.status = ST_UNDERFLOW;
                end else begin
                    shadow_fill--;
                    res.popped_value = shadow_stack[shadow_fill];
                end
            end
            OP_DELETE: begin
                if (index >= shadow_fill) begin
                    res.status = ST_BAD_INDEX;
                end else begin
                    for (int j = index; j + 1 < shadow_fill; j++)
                        shadow_stack[j] = shadow_stack[j + 1];
                    shadow_fill--;
                end
            end
            default: begin
                shadow_fill = 0;
            end
        endcase
        res.entry_count = shadow_fill[COUNT_W-1:0];
        return res;
    endfunction

    // hold the beat until the block takes it
    task automatic send_command(t_op op, logic [VALUE_W-1:0] value,
                                logic [INDEX_W-1:0] index);
        @(negedge i_clk);
        start          <= 1'b1;
        i_operation    <= op;
        i_push_value   <= value;
        i_delete_index <= index;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        pending_results.push_back(apply_stack_op(op, value, index));
    endtask

    task automatic hold_idle(int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        t_stack_result want;
        if (o_result_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result beat: value=%h status=%0d count=%0d",
                             o_popped_value, o_status, o_entry_count);
            end else begin
                want = pending_results.pop_front();
                if (o_popped_value !== want.popped_value || o_status !== want.status ||
                    o_entry_count !== want.entry_count) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected value=%h status=%0d count=%0d, got %s",
                                 want.popped_value, want.status, want.entry_count,
                                 $sformatf("value=%h status=%0d count=%0d",
                                           o_popped_value, o_status, o_entry_count));
                end
            end
        end
    end

    task automatic test_empty_stack();
        send_command(OP_POP, 32'h0, 6'd0);
        send_command(OP_DELETE, 32'h0, 6'd0);
        hold_idle(2);
        send_command(OP_DELETE, 32'hFFFF_FFFF, 6'd63);
        send_command(OP_CLEAR, 32'h0, 6'd0);
    endtask

    task automatic test_push_pop_extremes();
        send_command(OP_PUSH, 32'h0000_0000, 6'd0);
        send_command(OP_PUSH, 32'hFFFF_FFFF, 6'd63);
        send_command(OP_PUSH, 32'h8000_0001, 6'd0);
        send_command(OP_PUSH, 32'h7FFF_FFFE, 6'd0);
        send_command(OP_POP, 32'h0, 6'd0);
        hold_idle(1);
        send_command(OP_DELETE, 32'h0, 6'd3);
        send_command(OP_DELETE, 32'h0, 6'd2);
        send_command(OP_DELETE, 32'h0, 6'd0);
        send_command(OP_POP, 32'h0, 6'd0);
        send_command(OP_POP, 32'h0, 6'd0);
        hold_idle(3);
        send_command(OP_POP, 32'h0, 6'd0);
        send_command(OP_PUSH, 32'h5A5A_A5A5, 6'd0);
        send_command(OP_PUSH, 32'h1234_5678, 6'd0);
        send_command(OP_CLEAR, 32'h0, 6'd0);
        send_command(OP_POP, 32'h0, 6'd0);
    endtask

    task automatic test_full_stack();
        for (int k = 0; k < STACK_DEPTH; k++)
            send_command(OP_PUSH, $urandom, INDEX_W'($urandom));
        send_command(OP_PUSH, 32'hDEAD_BEEF, 6'd0);
        send_command(OP_PUSH, 32'h0, 6'd0);
        send_command(OP_DELETE, 32'h0, 6'd63);
        send_command(OP_PUSH, 32'hFFFF_FFFF, 6'd0);
        send_command(OP_DELETE, 32'h0, 6'd0);
        send_command(OP_DELETE, 32'h0, 6'd62);
        send_command(OP_DELETE, 32'h0, 6'd62);
        send_command(OP_DELETE, 32'h0, 6'd30);
        repeat (4) send_command(OP_POP, 32'h0, 6'd0);
        send_command(OP_CLEAR, 32'h0, 6'd0);
    endtask

    task automatic test_random_mix(int n_items);
        int                 sent;
        int                 burst;
        int                 roll;
        bit                 grow;
        t_op                op;
        logic [VALUE_W-1:0] value;
        logic [INDEX_W-1:0] index;
        sent = 0;
        grow = 1'b1;
        while (sent < n_items) begin
            burst = $urandom_range(1, 24);
            for (int b = 0; b < burst && sent < n_items; b++) begin
                if (shadow_fill >= STACK_DEPTH && $urandom_range(0, 3) == 0)
                    grow = 1'b0;
                else if (shadow_fill == 0)
                    grow = 1'b1;
                else if ($urandom_range(0, 49) == 0)
                    grow = ~grow;
                roll = $urandom_range(0, 99);
                if (roll < 2)
                    op = OP_CLEAR;
                else if (roll < (grow ? 72 : 30))
                    op = OP_PUSH;
                else if (roll < (grow ? 86 : 65))
                    op = OP_POP;
                else
                    op = OP_DELETE;
                if (shadow_fill > 0 && $urandom_range(0, 9) < 8)
                    index = INDEX_W'($urandom_range(0, shadow_fill - 1));
                else
                    index = INDEX_W'($urandom_range(0, 63));
                roll = $urandom_range(0, 9);
                value = (roll == 0) ? '0 : (roll == 1) ? '1 : VALUE_W'($urandom);
                send_command(op, value, index);
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                hold_idle($urandom_range(1, 8));
        end
    endtask

    initial begin
        int drain_cycles;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_operation    = OP_PUSH;
        i_push_value   = '0;
        i_delete_index = '0;
        shadow_fill    = 0;
        mismatch_count = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_stack();
        test_push_pop_extremes();
        test_full_stack();
        test_random_mix(1250);
        hold_idle(1);

        drain_cycles = 0;
        while (pending_results.size() != 0 && drain_cycles < 5000) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (80) @(posedge i_clk);
        if (pending_results.size() != 0)
            mismatch_count++;

        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
